// File: rtl/two_level_page_fault_fill_unit_defines.svh
// Assertion macros for the page fault fill unit
`ifndef TWO_LEVEL_PAGE_FAULT_FILL_UNIT_DEFINES_SVH
`define TWO_LEVEL_PAGE_FAULT_FILL_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define TLPF_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlpf assertion failed");
// next-cycle implication
`define TLPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlpf assertion failed");
`else
`define TLPF_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define TLPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/tlpf_pkg.sv
// Shared types and constants for the page fault fill unit
package tlpf_pkg;

    localparam int DEF_MAX_LEAF_TABLES = 64;
    localparam int ENTRIES_PER_TABLE   = 1024;
    localparam int DIR_DEPTH           = 1024;
    localparam int DIR_SHIFT           = 22;
    localparam int PAGE_SHIFT          = 12;
    localparam int IDX_W               = 10;
    localparam int FRAME_W             = 20;
    localparam int NEXT_W              = 21;
    localparam int REAL_W              = 21;
    localparam int AREA_W              = 11;
    localparam int TPAGE_W             = 11;
    localparam int CFG_W               = 21;

    localparam logic [REAL_W-1:0] REAL_PAGES_RST = 21'd32768;
    localparam logic [AREA_W-1:0] AREA_PAGES_RST = 11'd1024;
    localparam logic [AREA_W-1:0] AREA_MIN       = 11'd2;

    typedef enum logic [0:0] {
        REG_REAL_PAGES = 1'b0,
        REG_TABLE_AREA = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_NEW_MAP    = 2'd0,
        ST_MAPPED     = 2'd1,
        ST_TABLE_FULL = 2'd2,
        ST_MEM_FULL   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIR,
        S_LEAF,
        S_ZERO,
        S_DONE
    } state_t;

    // Table area size with small values raised to the minimum
    function automatic logic [AREA_W-1:0] area_eff(input logic [AREA_W-1:0] a);
        return (a < AREA_MIN) ? AREA_MIN : a;
    endfunction

endpackage

// File: rtl/tlpf_ram.sv
// Generic simple dual-port RAM with registered read
module tlpf_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/two_level_page_fault_fill_unit.sv
// Steps: an accepted fault reads the directory (S_DIR); if its leaf table exists, the leaf
// entry is read (S_LEAF); if not, the fault is refused or a new leaf table is allocated and its
// 1024 entries are cleared one per cycle through the leaf memory write port (S_ZERO).
// One item at a time: no new fault is accepted until the last one is through; the last step waits
// while the output register holds an item not yet taken. Reset: control registers clear at
// once, then a pass zeroes all 1024 directory entries; in_ready stays low meanwhile.
`include "two_level_page_fault_fill_unit_defines.svh"

module two_level_page_fault_fill_unit #(
    parameter int MAX_LEAF_TABLES = tlpf_pkg::DEF_MAX_LEAF_TABLES
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [31:0]               fault_address,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [31:0]               frame_address,
    output logic [31:0]               table_address,
    output logic                      table_created,
    output logic [1:0]                status,
    input  logic                      cfg_we,
    input  logic [0:0]                cfg_index,
    input  logic [tlpf_pkg::CFG_W-1:0] cfg_data
);

    import tlpf_pkg::*;

    localparam int CNT_W     = $clog2(MAX_LEAF_TABLES + 1);
    localparam int TBL_W     = (MAX_LEAF_TABLES > 1) ? $clog2(MAX_LEAF_TABLES) : 1;
    localparam int LEAF_DEP  = MAX_LEAF_TABLES * ENTRIES_PER_TABLE;
    localparam int LEAF_AW   = $clog2(LEAF_DEP);
    localparam int DIR_AW    = $clog2(DIR_DEPTH);

    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      di_reg, li_reg;
    logic [IDX_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      tables_used_reg;
    logic [TBL_W-1:0]      table_reg;
    logic [NEXT_W-1:0]     next_frame_reg;
    logic [REAL_W-1:0]     real_pages_reg;
    logic [AREA_W-1:0]     area_reg;

    // pending result
    logic [FRAME_W-1:0]    res_frame_reg;
    logic [TPAGE_W-1:0]    res_tpage_reg;
    logic                  res_created_reg;
    status_t               res_status_reg;

    // output register
    logic                  out_valid_reg;
    logic [FRAME_W-1:0]    out_frame_reg;
    logic [TPAGE_W-1:0]    out_tpage_reg;
    logic                  out_created_reg;
    status_t               out_status_reg;

    // memory ports
    logic                  dir_we;
    logic [DIR_AW-1:0]     dir_waddr, dir_raddr;
    logic [CNT_W-1:0]      dir_wdata, dir_rdata;
    logic                  leaf_we;
    logic [LEAF_AW-1:0]    leaf_waddr, leaf_raddr;
    logic [FRAME_W-1:0]    leaf_wdata, leaf_rdata;

    // control decoded from state
    logic                  res_load;
    logic [FRAME_W-1:0]    res_frame;
    logic [TPAGE_W-1:0]    res_tpage;
    logic                  res_created;
    status_t               res_status;
    logic                  frame_take;
    logic                  table_alloc;
    logic                  out_load;

    logic                  dir_hit, space_ok, frame_ok, cnt_last, out_free;
    logic [TBL_W-1:0]      dir_table;
    logic [AREA_W-1:0]     cfg_area_eff;

    // directory: table number + 1 per entry, 0 means no table
    tlpf_ram #(.WIDTH(CNT_W), .DEPTH(DIR_DEPTH)) u_dir_ram (
        .clk   (clk),
        .we    (dir_we),
        .waddr (dir_waddr),
        .wdata (dir_wdata),
        .raddr (dir_raddr),
        .rdata (dir_rdata)
    );

    // leaf entries: frame page number, 0 means empty
    tlpf_ram #(.WIDTH(FRAME_W), .DEPTH(LEAF_DEP)) u_leaf_ram (
        .clk   (clk),
        .we    (leaf_we),
        .waddr (leaf_waddr),
        .wdata (leaf_wdata),
        .raddr (leaf_raddr),
        .rdata (leaf_rdata)
    );

    // checks on current state
    assign dir_hit   = (dir_rdata != '0);
    assign dir_table = TBL_W'(dir_rdata - CNT_W'(1));
    assign space_ok  = (tables_used_reg < CNT_W'(MAX_LEAF_TABLES)) &&
                       ((12'(tables_used_reg) + 12'd2) < 12'(area_eff(area_reg)));
    assign frame_ok  = !next_frame_reg[NEXT_W-1] && (next_frame_reg < real_pages_reg);
    assign cnt_last  = (cnt_reg == '1);
    assign out_free  = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (cnt_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DIR;
                end
            end
            S_DIR:
            begin
                if (dir_hit)
                begin
                    state_next = S_LEAF;
                end
                else if (!space_ok || !frame_ok)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_ZERO;
                end
            end
            S_LEAF:
            begin
                state_next = S_DONE;
            end
            S_ZERO:
            begin
                if (cnt_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // memory controls and result selection
    always_comb
    begin
        dir_we      = 1'b0;
        dir_waddr   = di_reg;
        dir_wdata   = CNT_W'(CNT_W'(table_reg) + CNT_W'(1));
        dir_raddr   = fault_address[DIR_SHIFT +: IDX_W];
        leaf_we     = 1'b0;
        leaf_waddr  = LEAF_AW'({table_reg, li_reg});
        leaf_wdata  = next_frame_reg[FRAME_W-1:0];
        leaf_raddr  = LEAF_AW'({dir_table, li_reg});
        res_load    = 1'b0;
        res_frame   = '0;
        res_tpage   = '0;
        res_created = 1'b0;
        res_status  = ST_NEW_MAP;
        frame_take  = 1'b0;
        table_alloc = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                dir_we    = 1'b1;
                dir_waddr = cnt_reg;
                dir_wdata = '0;
            end
            S_DIR:
            begin
                if (!dir_hit && !space_ok)
                begin
                    res_load   = 1'b1;
                    res_status = ST_TABLE_FULL;
                end
                else if (!dir_hit && !frame_ok)
                begin
                    res_load   = 1'b1;
                    res_status = ST_MEM_FULL;
                end
            end
            S_LEAF:
            begin
                res_load  = 1'b1;
                res_tpage = TPAGE_W'(table_reg) + TPAGE_W'(2);
                if (leaf_rdata != '0)
                begin
                    res_frame  = leaf_rdata;
                    res_status = ST_MAPPED;
                end
                else if (!frame_ok)
                begin
                    res_status = ST_MEM_FULL;
                end
                else
                begin
                    leaf_we    = 1'b1;
                    res_frame  = next_frame_reg[FRAME_W-1:0];
                    res_status = ST_NEW_MAP;
                    frame_take = 1'b1;
                end
            end
            S_ZERO:
            begin
                // clear the new table, placing the frame at its slot
                leaf_we    = 1'b1;
                leaf_waddr = LEAF_AW'({table_reg, cnt_reg});
                leaf_wdata = (cnt_reg == li_reg) ? next_frame_reg[FRAME_W-1:0] : '0;
                dir_we     = (cnt_reg == '0);
                if (cnt_last)
                begin
                    res_load    = 1'b1;
                    res_frame   = next_frame_reg[FRAME_W-1:0];
                    res_tpage   = TPAGE_W'(table_reg) + TPAGE_W'(2);
                    res_created = 1'b1;
                    res_status  = ST_NEW_MAP;
                    frame_take  = 1'b1;
                    table_alloc = 1'b1;
                end
            end
            S_DONE:
            begin
                out_load = out_free;
            end
            default:
            begin
            end
        endcase
    end

    // control and allocator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            cnt_reg         <= '0;
            tables_used_reg <= '0;
            next_frame_reg  <= NEXT_W'(area_eff(AREA_PAGES_RST));
            real_pages_reg  <= REAL_PAGES_RST;
            area_reg        <= AREA_PAGES_RST;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // sweep counter for directory and table clears
            if (state_reg == S_CLEAR || state_reg == S_ZERO)
            begin
                cnt_reg <= cnt_reg + IDX_W'(1);
            end
            else
            begin
                cnt_reg <= '0;
            end

            if (table_alloc)
            begin
                tables_used_reg <= tables_used_reg + CNT_W'(1);
            end

            // frame bump pointer and configuration writes
            if (frame_take)
            begin
                next_frame_reg <= next_frame_reg + NEXT_W'(1);
            end
            else if (cfg_we && cfg_index == REG_TABLE_AREA)
            begin
                if (next_frame_reg < NEXT_W'(cfg_area_eff))
                begin
                    next_frame_reg <= NEXT_W'(cfg_area_eff);
                end
            end

            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_REAL_PAGES: real_pages_reg <= cfg_data[REAL_W-1:0];
                    REG_TABLE_AREA: area_reg       <= cfg_data[AREA_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign cfg_area_eff = area_eff(cfg_data[AREA_W-1:0]);

    // item fields, table number and result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            di_reg <= fault_address[DIR_SHIFT +: IDX_W];
            li_reg <= fault_address[PAGE_SHIFT +: IDX_W];
        end
        if (state_reg == S_DIR)
        begin
            table_reg <= dir_hit ? dir_table : TBL_W'(tables_used_reg);
        end
        if (res_load)
        begin
            res_frame_reg   <= res_frame;
            res_tpage_reg   <= res_tpage;
            res_created_reg <= res_created;
            res_status_reg  <= res_status;
        end
        if (out_load)
        begin
            out_frame_reg   <= res_frame_reg;
            out_tpage_reg   <= res_tpage_reg;
            out_created_reg <= res_created_reg;
            out_status_reg  <= res_status_reg;
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign frame_address = {out_frame_reg, {PAGE_SHIFT{1'b0}}};
    assign table_address = {{(32 - TPAGE_W - PAGE_SHIFT){1'b0}}, out_tpage_reg,
                            {PAGE_SHIFT{1'b0}}};
    assign table_created = out_created_reg;
    assign status        = out_status_reg;

    // checks
    `TLPF_ASSERT_SAME(a_tables_bound, clk, rst_n, 1'b1,
        tables_used_reg <= CNT_W'(MAX_LEAF_TABLES))
    `TLPF_ASSERT_SAME(a_frame_floor, clk, rst_n, 1'b1, next_frame_reg >= NEXT_W'(2))
    `TLPF_ASSERT_SAME(a_new_frame_real, clk, rst_n,
        out_valid && (status == ST_NEW_MAP || status == ST_MAPPED),
        frame_address[31:PAGE_SHIFT] >= 20'd2)
    `TLPF_ASSERT_SAME(a_created_new, clk, rst_n, out_valid && table_created,
        status == ST_NEW_MAP)
    `TLPF_ASSERT_NEXT(a_accept_reads_dir, clk, rst_n, in_valid && in_ready,
        state_reg == S_DIR)

endmodule
